[rtl/scf_pkg.sv]
// package: constants, phase type and checksum function for the serial command framer
`default_nettype none

package scf_pkg;

    localparam int FRAME_BYTES      = 10;
    localparam int RETRY_GAP_DEFAULT = 50;

    localparam logic [3:0] MAX_ATTEMPTS_RESET = 4'd3;

    // input modes
    localparam logic [1:0] MODE_CMD  = 2'd0;
    localparam logic [1:0] MODE_RX   = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    // frame bytes
    localparam logic [7:0] BYTE_START = 8'h7E;
    localparam logic [7:0] BYTE_VER   = 8'hFF;
    localparam logic [7:0] BYTE_LEN   = 8'h06;
    localparam logic [7:0] BYTE_END   = 8'hEF;

    // frame positions
    localparam logic [3:0] POS_CHK_LAST = 4'd8;
    localparam logic [3:0] POS_LAST     = 4'd9;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_GAP  = 2'd2
    } phase_t;

    // 16-bit two's complement negation of the sum of frame bytes 1 to 6
    function automatic logic [15:0] frame_check(
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic [7:0] b4,
        input logic [7:0] b5,
        input logic [7:0] b6
    );
        logic [15:0] s;
        s = 16'(b1) + 16'(b2) + 16'(b3) + 16'(b4) + 16'(b5) + 16'(b6);
        return 16'd0 - s;
    endfunction

endpackage

`default_nettype wire

[rtl/serial_command_framer_with_retry.sv]
// top level: command framer with checksum, response check and retry
`default_nettype none

// Serial command framer. A command transfer (mode 0) while idle builds the
// ten byte frame 7E FF 06 cmd fb ph pl chkH chkL EF and sends it out as ten
// output transfers, one byte per cycle while out_ready is high. Without
// feedback the last byte carries done_res and success. With feedback the block
// then collects received bytes (mode 1) and counts millisecond ticks (mode 2);
// the response is checked when ten bytes are in or on timeout, and a failed
// attempt waits RETRY_GAP_TICKS ticks before the frame is resent, up to
// max_attempts frames. A transfer that gives no result leaves the input ready;
// one that gives a status result or sends a frame holds the input until that
// result or the last frame byte is taken, and the next transfer can be taken
// then. The user must write max_attempts through cfg_wr_en/cfg_wr_data only
// while the block is idle; the block itself does not enforce it.

module serial_command_framer_with_retry
    import scf_pkg::*;
#(
    parameter int RETRY_GAP_TICKS = RETRY_GAP_DEFAULT
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  command,
    input  wire logic [15:0] parameter_req,
    input  wire logic        feedback,
    input  wire logic [11:0] timeout_ticks,
    input  wire logic [7:0]  rx_byte,
    // output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       tx_byte,
    output logic             tx_valid,
    output logic             last_in_run,
    output logic             done_res,
    output logic             success
);

    localparam logic [11:0] GAP_TICKS = 12'(RETRY_GAP_TICKS);

    // control state
    logic [3:0]  max_attempts_reg;
    phase_t      phase_reg, phase_next;
    logic [3:0]  rx_count_reg, rx_count_next;
    logic [3:0]  attempt_reg, attempt_next;
    logic [11:0] tick_reg, tick_next;
    logic [11:0] held_timeout_reg, held_timeout_next;
    logic        want_fb_reg, want_fb_next;

    // frame stores, no reset
    logic [7:0]  tx_frame_reg [FRAME_BYTES];
    logic [7:0]  rx_frame_reg [FRAME_BYTES];
    logic        tx_we;
    logic        rx_we;

    // result register and frame sequencer
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        tx_valid_reg, tx_valid_next;
    logic        last_reg, last_next;
    logic        done_reg, done_next;
    logic        success_reg, success_next;
    logic        frame_fin_reg, frame_fin_next;
    logic [3:0]  idx_reg, idx_next;

    logic        in_fire;
    logic        out_fire;

    // response check
    logic [7:0]  rx_view [FRAME_BYTES];
    logic [3:0]  rx_count_inc;
    logic [3:0]  rx_n;
    logic [3:0]  rx_last_idx;
    logic [7:0]  rx_last_byte;
    logic [15:0] rx_chk;
    logic        resp_ok;

    // per-transfer decisions
    logic [11:0] tick_inc;
    logic        finish;
    logic        do_send;
    logic        send_fb;
    logic        status_res;
    logic        status_ok;
    logic [15:0] tx_chk;
    logic [3:0]  idx_inc;

    assign in_ready = !out_valid_reg || (out_ready && last_reg);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    assign out_valid   = out_valid_reg;
    assign tx_byte     = tx_byte_reg;
    assign tx_valid    = tx_valid_reg;
    assign last_in_run = last_reg;
    assign done_res    = done_reg;
    assign success     = success_reg;

    assign rx_we        = in_fire && (mode == MODE_RX) && (phase_reg == PH_WAIT);
    assign rx_count_inc = rx_count_reg + 4'd1;
    assign rx_n         = rx_we ? rx_count_inc : rx_count_reg;
    assign rx_last_idx  = rx_n - 4'd1;
    assign tick_inc     = tick_reg + 12'd1;
    assign idx_inc      = idx_reg + 4'd1;
    assign tx_chk       = frame_check(BYTE_VER, BYTE_LEN, command, {7'd0, feedback},
                                      parameter_req[15:8], parameter_req[7:0]);

    // received frame with the byte arriving in this cycle merged in
    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            rx_view[i] = (rx_we && (rx_count_reg == 4'(i))) ? rx_byte : rx_frame_reg[i];
        end
    end

    always_comb
    begin
        rx_last_byte = 8'd0;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            if (rx_last_idx == 4'(i))
            begin
                rx_last_byte = rx_view[i];
            end
        end
    end

    assign rx_chk  = frame_check(rx_view[1], rx_view[2], rx_view[3],
                                 rx_view[4], rx_view[5], rx_view[6]);

    // start and end bytes always, checksum only once it has arrived
    assign resp_ok = (rx_n != 4'd0) && (rx_view[0] == BYTE_START)
                     && (rx_last_byte == BYTE_END)
                     && ((rx_n <= POS_CHK_LAST) || ({rx_view[7], rx_view[8]} == rx_chk));

    // command, response and retry control
    always_comb
    begin
        phase_next        = phase_reg;
        rx_count_next     = rx_count_reg;
        attempt_next      = attempt_reg;
        tick_next         = tick_reg;
        held_timeout_next = held_timeout_reg;
        want_fb_next      = want_fb_reg;
        tx_we             = 1'b0;
        finish            = 1'b0;
        do_send           = 1'b0;
        send_fb           = want_fb_reg;
        status_res        = 1'b0;
        status_ok         = 1'b0;

        if (in_fire)
        begin
            unique case (mode)
                MODE_CMD:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        want_fb_next      = feedback;
                        held_timeout_next = timeout_ticks;
                        tx_we             = 1'b1;
                        attempt_next      = 4'd0;
                        send_fb           = feedback;
                        if (max_attempts_reg == 4'd0)
                        begin
                            status_res = 1'b1;
                        end
                        else
                        begin
                            do_send = 1'b1;
                        end
                    end
                end
                MODE_RX:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        rx_count_next = rx_count_inc;
                        if (rx_count_inc == 4'(FRAME_BYTES))
                        begin
                            finish = 1'b1;
                        end
                    end
                end
                MODE_TICK:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        tick_next = tick_inc;
                        if ((tick_inc >= held_timeout_reg) || (held_timeout_reg == 12'd0))
                        begin
                            finish = 1'b1;
                        end
                    end
                    else if (phase_reg == PH_GAP)
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= GAP_TICKS)
                        begin
                            if (attempt_reg >= max_attempts_reg)
                            begin
                                phase_next = PH_IDLE;
                                status_res = 1'b1;
                            end
                            else
                            begin
                                do_send = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    // unused mode, ignored
                end
            endcase

            // response complete or timed out
            if (finish)
            begin
                if (resp_ok)
                begin
                    phase_next = PH_IDLE;
                    status_res = 1'b1;
                    status_ok  = 1'b1;
                end
                else
                begin
                    phase_next = PH_GAP;
                    tick_next  = 12'd0;
                end
            end

            if (do_send)
            begin
                attempt_next = ((mode == MODE_CMD) ? 4'd0 : attempt_reg) + 4'd1;
                if (send_fb)
                begin
                    phase_next    = PH_WAIT;
                    rx_count_next = 4'd0;
                    tick_next     = 12'd0;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    // result register: status result, frame start or frame advance
    always_comb
    begin
        out_valid_next = out_valid_reg;
        tx_byte_next   = tx_byte_reg;
        tx_valid_next  = tx_valid_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        success_next   = success_reg;
        frame_fin_next = frame_fin_reg;
        idx_next       = idx_reg;

        if (in_fire && do_send)
        begin
            out_valid_next = 1'b1;
            tx_byte_next   = BYTE_START;
            tx_valid_next  = 1'b1;
            last_next      = 1'b0;
            done_next      = 1'b0;
            success_next   = 1'b0;
            frame_fin_next = !send_fb;
            idx_next       = 4'd0;
        end
        else if (in_fire && status_res)
        begin
            out_valid_next = 1'b1;
            tx_byte_next   = 8'd0;
            tx_valid_next  = 1'b0;
            last_next      = 1'b1;
            done_next      = 1'b1;
            success_next   = status_ok;
        end
        else if (out_fire)
        begin
            if (last_reg)
            begin
                out_valid_next = 1'b0;
            end
            else
            begin
                // next frame byte, done flags only on the final byte
                idx_next      = idx_inc;
                tx_byte_next  = tx_frame_reg[idx_inc];
                last_next     = (idx_inc == POS_LAST);
                done_next     = (idx_inc == POS_LAST) && frame_fin_reg;
                success_next  = (idx_inc == POS_LAST) && frame_fin_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_attempts_reg <= MAX_ATTEMPTS_RESET;
            phase_reg        <= PH_IDLE;
            rx_count_reg     <= 4'd0;
            attempt_reg      <= 4'd0;
            tick_reg         <= 12'd0;
            held_timeout_reg <= 12'd0;
            want_fb_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            idx_reg          <= 4'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_attempts_reg <= cfg_wr_data;
            end
            phase_reg        <= phase_next;
            rx_count_reg     <= rx_count_next;
            attempt_reg      <= attempt_next;
            tick_reg         <= tick_next;
            held_timeout_reg <= held_timeout_next;
            want_fb_reg      <= want_fb_next;
            out_valid_reg    <= out_valid_next;
            idx_reg          <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tx_byte_reg   <= tx_byte_next;
        tx_valid_reg  <= tx_valid_next;
        last_reg      <= last_next;
        done_reg      <= done_next;
        success_reg   <= success_next;
        frame_fin_reg <= frame_fin_next;
    end

    // frame stores
    always_ff @(posedge clk)
    begin
        if (tx_we)
        begin
            tx_frame_reg[0] <= BYTE_START;
            tx_frame_reg[1] <= BYTE_VER;
            tx_frame_reg[2] <= BYTE_LEN;
            tx_frame_reg[3] <= command;
            tx_frame_reg[4] <= {7'd0, feedback};
            tx_frame_reg[5] <= parameter_req[15:8];
            tx_frame_reg[6] <= parameter_req[7:0];
            tx_frame_reg[7] <= tx_chk[15:8];
            tx_frame_reg[8] <= tx_chk[7:0];
            tx_frame_reg[9] <= BYTE_END;
        end
        if (rx_we)
        begin
            rx_frame_reg[rx_count_reg] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

[sim/testbench.sv]
// testbench: self-checking bench for the serial command framer and its reply predictor

module testbench;
    import scf_pkg::*;

    // ------------------------------------------------------------------
    // run constants
    // ------------------------------------------------------------------
    localparam int          GAP_TICKS    = RETRY_GAP_DEFAULT;
    localparam int          RANDOM_ITEMS = 100;      // items sent in the random part
    localparam int          DRAIN_CYCLES = 16;       // settle time before a register write
    localparam int          HOLD_CYCLES  = 300;      // long receiver hold-off
    localparam int          LIMIT        = 1000000;  // watchdog, in clock cycles
    localparam logic [1:0]  MODE_SPARE   = 2'd3;     // unused mode, ignored by the block

    // ten frame bytes, index 0 is the first on the line
    typedef logic [0:FRAME_BYTES-1][7:0] frame_t;

    // one input transfer
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  cmd;
        logic [15:0] arg;
        logic        fb;
        logic [11:0] ticks;
        logic [7:0]  rxb;
    } item_t;

    // one output transfer
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       last;
        logic       done;
        logic       ok;
    } result_t;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [3:0]  cfg_wr_data   = 4'd0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [1:0]  mode          = MODE_CMD;
    logic [7:0]  command       = 8'd0;
    logic [15:0] parameter_req = 16'd0;
    logic        feedback      = 1'b0;
    logic [11:0] timeout_ticks = 12'd0;
    logic [7:0]  rx_byte       = 8'd0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        last_in_run;
    logic        done_res;
    logic        success;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    serial_command_framer_with_retry #(
        .RETRY_GAP_TICKS (GAP_TICKS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .command       (command),
        .parameter_req (parameter_req),
        .feedback      (feedback),
        .timeout_ticks (timeout_ticks),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tx_byte       (tx_byte),
        .tx_valid      (tx_valid),
        .last_in_run   (last_in_run),
        .done_res      (done_res),
        .success       (success)
    );

    // ------------------------------------------------------------------
    // bench state shared between the processes
    // ------------------------------------------------------------------
    result_t     awaited_outputs[$];   // results still owed by the block, oldest first
    int unsigned mismatches     = 0;
    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned random_items   = 0;
    int unsigned cycle_count    = 0;
    int unsigned hold_cycles    = 0;   // set by a test, consumed by the receiver
    bit          steady         = 1'b0; // no idling on either side while set
    bit          in_random      = 1'b0;

    // predicted block state
    phase_t      cur_phase;
    frame_t      sent_frame;
    frame_t      reply_buf;
    logic [3:0]  reply_count;
    logic [3:0]  tries;
    logic [11:0] tick_cnt;
    logic [11:0] reply_timeout;
    logic        reply_wanted;
    logic [3:0]  try_limit;

    // ------------------------------------------------------------------
    // frame arithmetic
    // ------------------------------------------------------------------

    // 16-bit negated sum of bytes 1 to 6
    function automatic logic [15:0] frame_sum_neg(input frame_t f);
        logic [15:0] s;
        s = 16'd0;
        for (int i = 1; i < 7; i++)
            s = s + 16'(f[i]);
        return 16'd0 - s;
    endfunction

    function automatic frame_t build_frame(input logic [7:0] cmd, input logic [7:0] b4,
                                           input logic [15:0] arg);
        frame_t      f;
        logic [15:0] chk;
        f[0] = BYTE_START;
        f[1] = BYTE_VER;
        f[2] = BYTE_LEN;
        f[3] = cmd;
        f[4] = b4;
        f[5] = arg[15:8];
        f[6] = arg[7:0];
        chk  = frame_sum_neg(f);
        f[7] = chk[15:8];
        f[8] = chk[7:0];
        f[9] = BYTE_END;
        return f;
    endfunction

    // random well-formed reply frame from the partner
    function automatic frame_t random_reply();
        return build_frame(8'($urandom), 8'($urandom), 16'($urandom));
    endfunction

    // nine-byte reply whose checksum low byte is the end byte, so it passes
    function automatic frame_t nine_byte_reply();
        frame_t      f;
        logic [15:0] chk;
        f    = random_reply();
        chk  = frame_sum_neg(f);
        f[6] = f[6] + 8'h11 + chk[7:0];   // forces the byte sum to end in 11, so chk ends in EF
        chk  = frame_sum_neg(f);
        f[7] = chk[15:8];
        f[8] = chk[7:0];
        return f;
    endfunction

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void push_status(input logic ok);
        awaited_outputs.push_back('{tx_byte: 8'h00, tx_valid: 1'b0, last: 1'b1,
                                    done: 1'b1, ok: ok});
    endfunction

    function automatic void emit_frame();
        logic fin;
        tries = tries + 4'd1;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            fin = (i == FRAME_BYTES - 1) && !reply_wanted;
            awaited_outputs.push_back('{tx_byte: sent_frame[i], tx_valid: 1'b1,
                                        last: (i == FRAME_BYTES - 1), done: fin, ok: fin});
        end
        if (reply_wanted)
        begin
            cur_phase   = PH_WAIT;
            reply_count = 4'd0;
            tick_cnt    = 12'd0;
        end
        else
        begin
            cur_phase = PH_IDLE;
        end
    endfunction

    function automatic logic reply_ok();
        int unsigned n;
        n = reply_count;
        if (n == 0 || n > FRAME_BYTES)
            return 1'b0;
        if (reply_buf[0] != BYTE_START || reply_buf[n-1] != BYTE_END)
            return 1'b0;
        // checksum only counts once both its bytes are in
        if (n >= 9 && {reply_buf[7], reply_buf[8]} != frame_sum_neg(reply_buf))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic void close_attempt();
        if (reply_ok())
        begin
            cur_phase = PH_IDLE;
            push_status(1'b1);
        end
        else
        begin
            cur_phase = PH_GAP;
            tick_cnt  = 12'd0;
        end
    endfunction

    // advances the predicted state by one accepted input and queues its results
    function automatic void advance_framer(input item_t it);
        case (it.op)
            MODE_CMD:
            begin
                if (cur_phase == PH_IDLE)
                begin
                    reply_wanted  = it.fb;
                    reply_timeout = it.ticks;
                    sent_frame    = build_frame(it.cmd, {7'd0, it.fb}, it.arg);
                    tries         = 4'd0;
                    if (try_limit == 4'd0)
                        push_status(1'b0);
                    else
                        emit_frame();
                end
            end
            MODE_RX:
            begin
                if (cur_phase == PH_WAIT)
                begin
                    if (reply_count < FRAME_BYTES)
                    begin
                        reply_buf[reply_count] = it.rxb;
                        reply_count = reply_count + 4'd1;
                    end
                    if (reply_count >= FRAME_BYTES)
                        close_attempt();
                end
            end
            MODE_TICK:
            begin
                if (cur_phase == PH_WAIT)
                begin
                    tick_cnt = tick_cnt + 12'd1;
                    if (tick_cnt >= reply_timeout || reply_timeout == 12'd0)
                        close_attempt();
                end
                else if (cur_phase == PH_GAP)
                begin
                    tick_cnt = tick_cnt + 12'd1;
                    if (tick_cnt >= GAP_TICKS)
                    begin
                        // gap also follows the last failed attempt
                        if (tries >= try_limit)
                        begin
                            cur_phase = PH_IDLE;
                            push_status(1'b0);
                        end
                        else
                        begin
                            emit_frame();
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    function automatic item_t random_item(input logic [1:0] op);
        item_t it;
        // fields the mode does not use still carry random values
        it.op    = op;
        it.cmd   = 8'($urandom);
        it.arg   = 16'($urandom);
        it.fb    = 1'($urandom);
        it.ticks = 12'($urandom);
        it.rxb   = 8'($urandom);
        return it;
    endfunction

    // offers one item after a random pause, none while steady, and waits for its transfer
    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= it.op;
        command       <= it.cmd;
        parameter_req <= it.arg;
        feedback      <= it.fb;
        timeout_ticks <= it.ticks;
        rx_byte       <= it.rxb;
        do @(posedge clk); while (!in_ready);
        if (in_random)
            random_items++;
        advance_framer(it);
        items_sent++;
    endtask

    task automatic send_cmd(input logic [7:0] cmd, input logic [15:0] arg, input logic fb,
                            input logic [11:0] ticks);
        item_t it;
        it       = random_item(MODE_CMD);
        it.cmd   = cmd;
        it.arg   = arg;
        it.fb    = fb;
        it.ticks = ticks;
        send_item(it);
    endtask

    task automatic send_byte(input logic [7:0] b);
        item_t it;
        it     = random_item(MODE_RX);
        it.rxb = b;
        send_item(it);
    endtask

    task automatic send_tick();
        send_item(random_item(MODE_TICK));
    endtask

    // first n bytes of a reply, with a tick slipped in now and then if asked
    task automatic send_reply(input frame_t f, input int n, input bit mix_ticks);
        for (int i = 0; i < n; i++)
        begin
            if (mix_ticks && $urandom_range(0, 7) == 0)
                send_tick();
            send_byte(f[i]);
        end
    endtask

    task automatic tick_while(input phase_t p);
        while (cur_phase == p)
            send_tick();
    endtask

    // ticks until the command has reported done
    task automatic finish_command();
        while (cur_phase != PH_IDLE)
            send_tick();
    endtask

    // drops the input and waits until every owed result has arrived
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_try_limit(input logic [3:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        try_limit    = v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // receiver side: a random pause before every result unless steady, or a long hold-off
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned pause;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles != 0)
            begin
                pause       = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                pause = steady ? 0 : $urandom_range(0, 12);
            end
            if (pause != 0)
            begin
                out_ready <= 1'b0;
                repeat (pause) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_outputs.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got tx_byte %02h valid %0b",
                         $time, tx_byte, tx_valid);
                $display("%0t:   last %0b done %0b success %0b",
                         $time, last_in_run, done_res, success);
                mismatches++;
            end
            else
            begin
                want = awaited_outputs.pop_front();
                compare_field("tx_byte", want.tx_byte, tx_byte);
                compare_field("tx_valid", 8'(want.tx_valid), 8'(tx_valid));
                compare_field("last_in_run", 8'(want.last), 8'(last_in_run));
                compare_field("done_res", 8'(want.done), 8'(done_res));
                compare_field("success", 8'(want.ok), 8'(success));
                results_seen++;
            end
        end
    end

    // watchdog
    initial
    begin : watchdog
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                 awaited_outputs.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // frames without feedback at field extremes, plus items the block ignores
    task automatic test_plain_frames();
        send_cmd(8'h00, 16'h0000, 1'b0, 12'h000);
        send_cmd(8'hFF, 16'hFFFF, 1'b0, 12'hFFF);
        send_tick();                           // stray tick while idle
        send_byte(8'h7E);                      // stray byte while idle
        send_item(random_item(MODE_SPARE));    // unused mode
    endtask

    // a full correct reply; a new command during the wait is dropped
    task automatic test_reply_accepted();
        send_cmd(8'h3A, 16'h1234, 1'b1, 12'd5);
        send_cmd(8'h11, 16'h5555, 1'b0, 12'd0);
        send_reply(random_reply(), FRAME_BYTES, 1'b0);
    endtask

    // limit of zero sends nothing; limit of fifteen survives an empty timeout
    task automatic test_attempt_limits();
        set_try_limit(4'd0);
        send_cmd(8'h42, 16'hBEEF, 1'b1, 12'd3);
        set_try_limit(4'd15);
        send_cmd(8'h0D, 16'h00FF, 1'b1, 12'd0);
        send_tick();                           // zero timeout ends the wait at once
        send_byte(8'hEF);                      // stray byte during the gap
        tick_while(PH_GAP);
        send_reply(random_reply(), FRAME_BYTES, 1'b0);
    endtask

    // partial replies checked on timeout, and the final failure after the gap
    task automatic test_timeouts();
        set_try_limit(4'd1);
        send_cmd(8'h21, 16'hA5A5, 1'b1, 12'd3);
        send_byte(BYTE_START);
        send_byte(8'h55);
        send_byte(BYTE_END);
        finish_command();
        send_cmd(8'h22, 16'h5A5A, 1'b1, 12'd2);
        send_reply(nine_byte_reply(), 9, 1'b0);
        finish_command();
        send_cmd(8'h23, 16'h0F0F, 1'b1, 12'd1);
        send_byte(BYTE_START);
        finish_command();
    endtask

    // bad checksum, then a bad end byte on the retry, then failure
    task automatic test_retry();
        frame_t f;
        set_try_limit(4'd2);
        send_cmd(8'h5C, 16'h8001, 1'b1, 12'd4);
        f    = random_reply();
        f[8] = f[8] ^ 8'h01;
        send_reply(f, FRAME_BYTES, 1'b0);
        tick_while(PH_GAP);
        f    = random_reply();
        f[9] = 8'hEE;
        send_reply(f, FRAME_BYTES, 1'b0);
        finish_command();
    endtask

    // longest timeout, answered after a few ticks, back to back
    task automatic test_long_timeout();
        set_try_limit(4'd1);
        steady = 1'b1;
        send_cmd(8'hC3, 16'h7FFE, 1'b1, 12'hFFF);
        repeat (3)
            send_tick();
        send_reply(random_reply(), FRAME_BYTES, 1'b0);
        wait_drained();
        steady = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering frames
    task automatic test_backpressure();
        set_try_limit(4'd3);
        hold_cycles = HOLD_CYCLES;
        repeat (4)
            send_cmd(8'($urandom), 16'($urandom), 1'b0, 12'($urandom));
        send_cmd(8'($urandom), 16'($urandom), 1'b1, 12'd6);
        send_reply(random_reply(), FRAME_BYTES, 1'b0);
    endtask

    // one random command with its replies, noise and retries until done
    task automatic run_scenario();
        frame_t      f;
        int unsigned n;
        logic [11:0] ticks;
        ticks = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 40))
                                            : 12'($urandom_range(0, 6));
        send_cmd(8'($urandom), 16'($urandom), ($urandom_range(0, 3) != 0), ticks);
        if ($urandom_range(0, 5) == 0)
            send_item(random_item(MODE_CMD));   // dropped if the block is busy
        while (cur_phase != PH_IDLE)
        begin
            if (cur_phase == PH_GAP)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(random_item(MODE_RX));
                send_tick();
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                        send_reply(random_reply(), FRAME_BYTES, 1'b1);
                    4, 5:
                    begin
                        // one flipped bit anywhere breaks the reply
                        f = random_reply();
                        n = $urandom_range(0, FRAME_BYTES - 1);
                        f[n] = f[n] ^ (8'd1 << $urandom_range(0, 7));
                        send_reply(f, FRAME_BYTES, 1'b1);
                    end
                    6:
                    begin
                        // short reply, mostly well-bounded, checked on timeout
                        n = $urandom_range(1, 9);
                        f = (n == 9 && $urandom_range(0, 1)) ? nine_byte_reply()
                                                              : random_reply();
                        if (n != 9 && $urandom_range(0, 3) != 0)
                            f[n-1] = BYTE_END;
                        send_reply(f, n, 1'b0);
                        tick_while(PH_WAIT);
                    end
                    7:
                        tick_while(PH_WAIT);
                    8:
                    begin
                        repeat ($urandom_range(1, FRAME_BYTES))
                            send_item(random_item(MODE_RX));
                        tick_while(PH_WAIT);
                    end
                    default:
                        send_item(random_item(($urandom_range(0, 1) != 0) ? MODE_SPARE
                                                                         : MODE_CMD));
                endcase
            end
        end
    endtask

    task automatic test_random();
        int unsigned runs;
        runs      = 0;
        in_random = 1'b1;
        while (random_items < RANDOM_ITEMS)
        begin
            if (runs % 3 == 0)
            begin
                if ($urandom_range(0, 9) < 7)
                    set_try_limit(4'($urandom_range(1, 3)));
                else
                    set_try_limit(($urandom_range(0, 1) != 0) ? 4'd0
                                                               : 4'($urandom_range(4, 15)));
            end
            steady = ($urandom_range(0, 3) == 0);
            run_scenario();
            runs++;
        end
        in_random = 1'b0;
        steady    = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        // predicted state after reset
        cur_phase     = PH_IDLE;
        sent_frame    = '0;
        reply_buf     = '0;
        reply_count   = 4'd0;
        tries         = 4'd0;
        tick_cnt      = 12'd0;
        reply_timeout = 12'd0;
        reply_wanted  = 1'b0;
        try_limit     = MAX_ATTEMPTS_RESET;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_plain_frames();
        test_reply_accepted();
        test_attempt_limits();
        test_timeouts();
        test_retry();
        test_long_timeout();
        test_backpressure();
        test_random();

        wait_drained();
        $display("%0d items accepted, %0d results checked, %0d mismatches",
                 items_sent, results_seen, mismatches);
        $display("covered plain frames, good, short and corrupt replies, timeouts, retries,");
        $display("attempt limits 0 to 15 and a long output stall");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/scf_pkg.sv
rtl/serial_command_framer_with_retry.sv
sim/testbench.sv
